// ----- design/rdsc_pkg.sv -----
// Package: word types, codes and the microcode program of the radix digit string converter
`timescale 1ns / 1ps
package rdsc_pkg;

	// input word: one ascii character
	typedef struct packed {
		logic [7:0] char_code;
		logic       is_last;
	} in_word_t;

	// output word: one result
	typedef struct packed {
		logic [7:0] digit_char;
		logic [7:0] value;
		logic [1:0] status;
		logic       run_end;
	} out_word_t;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO     = 2'd1;
	localparam logic [1:0] ST_INVALID  = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	// configuration register indexes
	localparam logic CFG_IN_RADIX    = 1'b0;
	localparam logic CFG_OUTPUT_BASE = 1'b1;

	// ascii constants
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_GAP   = 8'h20;

	// digit buffer depth
	localparam int DIGIT_SLOTS = 8;

	// datapath operations
	typedef enum logic [3:0] {
		OP_TAKE,
		OP_NOP,
		OP_LOAD,
		OP_DIV_STEP,
		OP_STORE,
		OP_EMIT_DIGIT,
		OP_CLEAR,
		OP_EMIT_STATUS
	} op_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NOT_LAST,
		C_FAULT,
		C_DIV_BUSY,
		C_MORE_DIGITS,
		C_MORE_OUT
	} cond_t;

	typedef logic [2:0] step_t;

	// step addresses
	localparam step_t STEP_TAKE   = 3'd0;
	localparam step_t STEP_CHECK  = 3'd1;
	localparam step_t STEP_LOAD   = 3'd2;
	localparam step_t STEP_DIV    = 3'd3;
	localparam step_t STEP_STORE  = 3'd4;
	localparam step_t STEP_EMIT   = 3'd5;
	localparam step_t STEP_CLEAR  = 3'd6;
	localparam step_t STEP_STATUS = 3'd7;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_word_t;

	// microcode program
	function automatic ctrl_word_t micro_rom(input step_t step);
		ctrl_word_t w;
		w = '{op: OP_CLEAR, cond: C_ALWAYS, target: STEP_TAKE};
		unique case (step)
			STEP_TAKE:   w = '{op: OP_TAKE,        cond: C_NOT_LAST,    target: STEP_TAKE};
			STEP_CHECK:  w = '{op: OP_NOP,         cond: C_FAULT,       target: STEP_STATUS};
			STEP_LOAD:   w = '{op: OP_LOAD,        cond: C_NEVER,       target: STEP_TAKE};
			STEP_DIV:    w = '{op: OP_DIV_STEP,    cond: C_DIV_BUSY,    target: STEP_DIV};
			STEP_STORE:  w = '{op: OP_STORE,       cond: C_MORE_DIGITS, target: STEP_DIV};
			STEP_EMIT:   w = '{op: OP_EMIT_DIGIT,  cond: C_MORE_OUT,    target: STEP_EMIT};
			STEP_CLEAR:  w = '{op: OP_CLEAR,       cond: C_ALWAYS,      target: STEP_TAKE};
			STEP_STATUS: w = '{op: OP_EMIT_STATUS, cond: C_ALWAYS,      target: STEP_CLEAR};
			default:     w = '{op: OP_CLEAR,       cond: C_ALWAYS,      target: STEP_TAKE};
		endcase
		return w;
	endfunction

endpackage

// ----- design/radix_digit_string_converter.sv -----
// Radix digit string converter: microcoded sequencer with a shift-subtract divider
//
// Input channel in_valid/in_stall/in_word moves one ascii digit word per accept,
// most significant first; in_word.is_last closes the number. Each digit is checked
// against the input radix and folded in as value*base+digit in the cycle it is
// accepted. The last word starts a microcode program, with in_stall high until
// it is back at its take step: a check step, a load step, then for every output
// digit AW restoring divide steps (AW = bits of MAX_VALUE) plus a store step,
// then one result word per cycle while the receiver does not stall, most
// significant digit first, and a clear step. An error or zero number skips to a
// single status word and the clear step.
// Output channel out_valid/out_stall/out_word is driven from an output register;
// while the receiver stalls, the word holds and the program waits at its emit step.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 input base,
// 1 output base); bases outside 2..16 act as the nearest end.
// Reset (arst_n low) sets bases to 10 and 2, clears the value, flags and output valid.
`timescale 1ns / 1ps
module radix_digit_string_converter
	import rdsc_pkg::*;
#(
	parameter int MAX_VALUE = 255
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word,
	input  logic      cfg_we,
	input  logic      cfg_index,
	input  logic [4:0] cfg_data
);

	localparam int AW = $clog2(MAX_VALUE + 1);
	localparam int PW = AW + 6;
	localparam int CW = $clog2(AW);
	localparam logic [AW-1:0] MAX_ACC = AW'(MAX_VALUE);
	localparam logic [PW-1:0] MAX_WIDE = PW'(MAX_VALUE);
	localparam logic [CW-1:0] CNT_LAST = CW'(AW - 1);
	localparam int SW = $clog2(DIGIT_SLOTS);
	localparam logic [SW:0] SLOT_TOP = (SW + 1)'(DIGIT_SLOTS - 1);

	logic [4:0]    in_radix_q;
	logic [4:0]    output_base_q;
	logic [AW-1:0] acc_q;
	logic          overflow_q;
	logic          invalid_q;
	step_t         step_q;
	logic [AW-1:0] div_q;
	logic [4:0]    rem_q;
	logic [CW-1:0] cnt_q;
	logic [SW:0]   n_q;
	logic [SW-1:0] k_q;
	logic [7:0]    digit_buf_q [DIGIT_SLOTS];
	logic          out_valid_q;
	out_word_t     out_q;

	ctrl_word_t    cw;
	logic          in_accept;
	logic          slot_free;
	logic          hold;
	logic          jump;
	logic [4:0]    ib;
	logic [4:0]    ob;
	logic [7:0]    up_char;
	logic [4:0]    digit;
	logic          digit_bad;
	logic [PW-1:0] fold;
	logic [4:0]    trial;
	logic          trial_ge;
	logic [7:0]    rem_char;
	logic [SW-1:0] emit_idx;
	logic [1:0]    fault_status;

	// control word of the current step
	assign cw = micro_rom(step_q);

	// handshakes
	assign in_stall  = (cw.op != OP_TAKE);
	assign in_accept = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// base clamping
	always_comb begin
		ib = (in_radix_q < 5'd2) ? 5'd2 : ((in_radix_q > 5'd16) ? 5'd16 : in_radix_q);
		ob = (output_base_q < 5'd2) ? 5'd2 : ((output_base_q > 5'd16) ? 5'd16 : output_base_q);
	end

	// digit decode and fold
	always_comb begin
		up_char = in_word.char_code;
		if (up_char >= CH_LOWER_A && up_char <= CH_LOWER_Z) begin
			up_char = up_char - CASE_GAP;
		end
		if (up_char >= CH_ZERO && up_char <= CH_NINE) begin
			digit = 5'(up_char - CH_ZERO);
		end else if (up_char >= CH_UPPER_A && up_char <= CH_UPPER_F) begin
			digit = 5'(up_char - CH_UPPER_A) + 5'd10;
		end else begin
			digit = 5'd16;
		end
		digit_bad = (digit >= ib);
		fold = PW'(acc_q) * PW'(ib) + PW'(digit);
	end

	// divider trial subtract, digit character, emit index and fault status
	always_comb begin
		trial    = {rem_q[3:0], div_q[AW-1]};
		trial_ge = (trial >= ob);
		rem_char = (rem_q < 5'd10) ? (CH_ZERO + 8'(rem_q)) : (CH_UPPER_A + 8'(rem_q - 5'd10));
		emit_idx = SW'(n_q - (SW + 1)'(1) - (SW + 1)'(k_q));
		if (invalid_q) begin
			fault_status = ST_INVALID;
		end else if (overflow_q) begin
			fault_status = ST_OVERFLOW;
		end else begin
			fault_status = ST_ZERO;
		end
	end

	// step hold and jump decision
	always_comb begin
		hold = ((cw.op == OP_TAKE) && !in_accept) ||
			(((cw.op == OP_EMIT_DIGIT) || (cw.op == OP_EMIT_STATUS)) && !slot_free);
		case (cw.cond)
			C_ALWAYS:      jump = 1'b1;
			C_NOT_LAST:    jump = !in_word.is_last;
			C_FAULT:       jump = invalid_q || overflow_q || (acc_q == '0);
			C_DIV_BUSY:    jump = (cnt_q != CNT_LAST);
			C_MORE_DIGITS: jump = (div_q != '0) && (n_q != SLOT_TOP);
			C_MORE_OUT:    jump = ((SW + 1)'(k_q) != (n_q - (SW + 1)'(1)));
			default:       jump = 1'b0;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_radix_q    <= 5'd10;
			output_base_q <= 5'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IN_RADIX:    in_radix_q    <= cfg_data;
				CFG_OUTPUT_BASE: output_base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_TAKE;
			acc_q       <= '0;
			overflow_q  <= 1'b0;
			invalid_q   <= 1'b0;
			out_valid_q <= 1'b0;
			n_q         <= '0;
			k_q         <= '0;
			cnt_q       <= '0;
		end else begin
			// output word valid
			if (!hold && ((cw.op == OP_EMIT_DIGIT) || (cw.op == OP_EMIT_STATUS))) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (!hold) begin
				step_q <= jump ? cw.target : step_q + step_t'(1);
				unique case (cw.op)
					OP_TAKE: begin
						if (digit_bad) begin
							invalid_q <= 1'b1;
						end else if (fold > MAX_WIDE) begin
							overflow_q <= 1'b1;
							acc_q      <= MAX_ACC;
						end else begin
							acc_q <= AW'(fold);
						end
					end
					OP_LOAD: begin
						n_q   <= '0;
						cnt_q <= '0;
					end
					OP_DIV_STEP: begin
						cnt_q <= cnt_q + CW'(1);
					end
					OP_STORE: begin
						n_q   <= n_q + (SW + 1)'(1);
						cnt_q <= '0;
						k_q   <= '0;
					end
					OP_EMIT_DIGIT: begin
						k_q <= k_q + SW'(1);
					end
					OP_CLEAR: begin
						acc_q      <= '0;
						overflow_q <= 1'b0;
						invalid_q  <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	// datapath payload registers
	always_ff @(posedge clk) begin
		if (!hold) begin
			case (cw.op)
				OP_LOAD: begin
					div_q <= acc_q;
					rem_q <= '0;
				end
				OP_DIV_STEP: begin
					rem_q <= trial_ge ? (trial - ob) : trial;
					div_q <= {div_q[AW-2:0], trial_ge};
				end
				OP_STORE: begin
					digit_buf_q[n_q[SW-1:0]] <= rem_char;
					rem_q <= '0;
				end
				OP_EMIT_DIGIT: begin
					out_q.digit_char <= digit_buf_q[emit_idx];
					out_q.value      <= 8'(acc_q);
					out_q.status     <= ST_OK;
					out_q.run_end    <= !jump;
				end
				OP_EMIT_STATUS: begin
					out_q.digit_char <= '0;
					out_q.value      <= '0;
					out_q.status     <= fault_status;
					out_q.run_end    <= 1'b1;
				end
				default: ;
			endcase
		end
	end

endmodule

// ----- bench/tb.sv -----
// Testbench: radix digit string converter checked word by word against a conversion predictor
`timescale 1ns / 1ps
module tb;
	import rdsc_pkg::*;

	localparam int unsigned VALUE_LIMIT = 255;

	typedef enum logic {ROW_CHAR, ROW_REG} row_kind_t;

	// one line of the directed table
	typedef struct {
		row_kind_t  kind;
		in_word_t   word;
		logic       reg_index;
		logic [4:0] reg_data;
		logic       fixed;
		out_word_t  fixed_word;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_word_t   in_word = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_word_t  out_word;
	logic       cfg_we = 1'b0;
	logic       cfg_index = CFG_IN_RADIX;
	logic [4:0] cfg_data = '0;

	// conversion state as the block should hold it
	logic [4:0]  in_radix = 5'd10;
	logic [4:0]  out_radix = 5'd2;
	int unsigned running_value = 0;
	logic        overflow_seen = 1'b0;
	logic        invalid_seen = 1'b0;

	out_word_t expected_words[$];
	stim_row_t directed_rows[$];
	out_word_t oldest_word;
	int        mismatch_count = 0;
	logic      calm = 1'b0;

	radix_digit_string_converter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic int unsigned clamp_radix(input logic [4:0] r);
		if (r < 5'd2) return 2;
		if (r > 5'd16) return 16;
		return r;
	endfunction

	// digit value of a character, 16 when it is no hex digit
	function automatic int unsigned digit_value(input logic [7:0] c);
		logic [7:0] u;
		u = c;
		if (u >= CH_LOWER_A && u <= CH_LOWER_Z) u = u - CASE_GAP;
		if (u >= CH_ZERO && u <= CH_NINE) return u - CH_ZERO;
		if (u >= CH_UPPER_A && u <= CH_UPPER_F) return u - CH_UPPER_A + 10;
		return 16;
	endfunction

	function automatic logic [7:0] digit_char_of(input int unsigned r);
		return (r < 10) ? CH_ZERO + 8'(r) : CH_UPPER_A + 8'(r - 10);
	endfunction

	// mostly legal bases, sometimes any 5-bit value
	function automatic logic [4:0] pick_radix();
		if ($urandom_range(3) == 0) return 5'($urandom_range(31));
		return 5'($urandom_range(2, 16));
	endfunction

	function automatic stim_row_t char_row(input logic [7:0] ch, input logic last,
			input logic fixed = 1'b0, input logic [1:0] st = ST_OK);
		stim_row_t r;
		r.kind = ROW_CHAR;
		r.word.char_code = ch;
		r.word.is_last = last;
		r.reg_index = CFG_IN_RADIX;
		r.reg_data = '0;
		r.fixed = fixed;
		r.fixed_word = '{digit_char: 8'h00, value: 8'h00, status: st, run_end: 1'b1};
		return r;
	endfunction

	function automatic stim_row_t reg_row(input logic idx, input logic [4:0] val);
		stim_row_t r;
		r = char_row(8'h00, 1'b0);
		r.kind = ROW_REG;
		r.reg_index = idx;
		r.reg_data = val;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	// fold one character into the value; on the last one, list the words it gives
	task automatic convert_char(input in_word_t w, output out_word_t words[$]);
		int unsigned radix, d, nxt, v, n;
		logic [7:0]  digs[DIGIT_SLOTS];
		out_word_t   o;
		words = {};
		radix = clamp_radix(in_radix);
		d = digit_value(w.char_code);
		if (d >= radix) begin
			invalid_seen = 1'b1;
		end else begin
			nxt = running_value * radix + d;
			if (nxt > VALUE_LIMIT) begin
				overflow_seen = 1'b1;
				nxt = VALUE_LIMIT;
			end
			running_value = nxt;
		end
		if (w.is_last) begin
			if (invalid_seen || overflow_seen || running_value == 0) begin
				o = '0;
				o.run_end = 1'b1;
				o.status = invalid_seen ? ST_INVALID : (overflow_seen ? ST_OVERFLOW : ST_ZERO);
				words.push_back(o);
			end else begin
				radix = clamp_radix(out_radix);
				v = running_value;
				n = 0;
				while (v > 0 && n < DIGIT_SLOTS) begin
					digs[n] = digit_char_of(v % radix);
					n++;
					v = v / radix;
				end
				// most significant digit first
				for (int k = n - 1; k >= 0; k--) begin
					o.digit_char = digs[k];
					o.value = 8'(running_value);
					o.status = ST_OK;
					o.run_end = (k == 0);
					words.push_back(o);
				end
			end
			running_value = 0;
			overflow_seen = 1'b0;
			invalid_seen = 1'b0;
		end
	endtask

	// offer one word, wait for the accept, then queue what it should give
	task automatic send_word(input in_word_t w, input logic fixed, input out_word_t fixed_word);
		out_word_t words[$];
		logic      taken;
		if (!calm && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		convert_char(w, words);
		if (fixed) expected_words.push_back(fixed_word);
		else foreach (words[i]) expected_words.push_back(words[i]);
	endtask

	// register write once the block has drained
	task automatic write_register(input logic idx, input logic [4:0] val);
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_IN_RADIX) in_radix = val;
		else out_radix = val;
	endtask

	// receiver stalls at random except in the calm stretch
	always @(posedge clk) begin
		if (!arst_n || calm) out_stall <= 1'b0;
		else out_stall <= ($urandom_range(99) < 16);
	end

	// compare each accepted result word with the oldest expectation
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("word %h with nothing expected", out_word));
			end else begin
				oldest_word = expected_words.pop_front();
				if (out_word.digit_char !== oldest_word.digit_char)
					report_mismatch($sformatf("digit_char got %h want %h",
						out_word.digit_char, oldest_word.digit_char));
				if (out_word.value !== oldest_word.value)
					report_mismatch($sformatf("value got %h want %h",
						out_word.value, oldest_word.value));
				if (out_word.status !== oldest_word.status)
					report_mismatch($sformatf("status got %h want %h",
						out_word.status, oldest_word.status));
				if (out_word.run_end !== oldest_word.run_end)
					report_mismatch($sformatf("run_end got %b want %b",
						out_word.run_end, oldest_word.run_end));
			end
		end
	end

	initial begin
		stim_row_t   row;
		out_word_t   none;
		in_word_t    w;
		int          random_items;
		int          numbers_done;
		int          len;
		int          wait_cycles;
		int unsigned radix, d;
		logic        all_zero;
		none = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: reset bases first
		directed_rows.push_back(char_row("0", 1'b1, 1'b1, ST_ZERO));
		directed_rows.push_back(char_row("2", 1'b0));
		directed_rows.push_back(char_row("5", 1'b0));
		directed_rows.push_back(char_row("5", 1'b1));
		directed_rows.push_back(char_row("2", 1'b0));
		directed_rows.push_back(char_row("5", 1'b0));
		directed_rows.push_back(char_row("6", 1'b1, 1'b1, ST_OVERFLOW));
		directed_rows.push_back(char_row("x", 1'b0));
		directed_rows.push_back(char_row("1", 1'b1, 1'b1, ST_INVALID));
		// overflow then a bad digit: invalid wins
		directed_rows.push_back(char_row("9", 1'b0));
		directed_rows.push_back(char_row("9", 1'b0));
		directed_rows.push_back(char_row("9", 1'b0));
		directed_rows.push_back(char_row("z", 1'b1, 1'b1, ST_INVALID));
		// hex in and out, mixed case, byte extremes
		directed_rows.push_back(reg_row(CFG_IN_RADIX, 5'd16));
		directed_rows.push_back(reg_row(CFG_OUTPUT_BASE, 5'd16));
		directed_rows.push_back(char_row("f", 1'b0));
		directed_rows.push_back(char_row("F", 1'b1));
		directed_rows.push_back(char_row(8'hFF, 1'b1, 1'b1, ST_INVALID));
		directed_rows.push_back(char_row(8'h00, 1'b1, 1'b1, ST_INVALID));
		// out of range bases act as the nearest end
		directed_rows.push_back(reg_row(CFG_IN_RADIX, 5'd0));
		directed_rows.push_back(reg_row(CFG_OUTPUT_BASE, 5'd31));
		directed_rows.push_back(char_row("1", 1'b0));
		directed_rows.push_back(char_row("0", 1'b0));
		directed_rows.push_back(char_row("1", 1'b1));
		directed_rows.push_back(char_row("2", 1'b1, 1'b1, ST_INVALID));
		directed_rows.push_back(reg_row(CFG_IN_RADIX, 5'd17));
		directed_rows.push_back(reg_row(CFG_OUTPUT_BASE, 5'd1));
		directed_rows.push_back(char_row("a", 1'b0));
		directed_rows.push_back(char_row("B", 1'b1));
		directed_rows.push_back(reg_row(CFG_IN_RADIX, 5'd10));
		directed_rows.push_back(reg_row(CFG_OUTPUT_BASE, 5'd10));
		directed_rows.push_back(char_row("7", 1'b1));

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_REG) write_register(row.reg_index, row.reg_data);
			else send_word(row.word, row.fixed, row.fixed_word);
		end

		// random numbers, mostly well formed, with new settings every few numbers
		random_items = 0;
		numbers_done = 0;
		while (random_items < 260) begin
			if (numbers_done % 8 == 7) begin
				if ($urandom_range(1)) write_register(CFG_IN_RADIX, pick_radix());
				if ($urandom_range(1)) write_register(CFG_OUTPUT_BASE, pick_radix());
			end
			calm = (numbers_done >= 30 && numbers_done < 50);
			len = ($urandom_range(9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
			all_zero = ($urandom_range(11) == 0);
			radix = clamp_radix(in_radix);
			for (int k = 0; k < len; k++) begin
				w.is_last = (k == len - 1);
				if ($urandom_range(99) < 8) begin
					w.char_code = 8'($urandom_range(255));
				end else if (all_zero) begin
					w.char_code = CH_ZERO;
				end else begin
					d = $urandom_range(radix - 1);
					w.char_code = digit_char_of(d);
					if (d >= 10 && $urandom_range(1)) w.char_code = w.char_code + CASE_GAP;
				end
				send_word(w, 1'b0, none);
				random_items++;
			end
			numbers_done++;
		end
		calm = 1'b0;

		// drain and settle
		in_valid <= 1'b0;
		wait_cycles = 0;
		while (expected_words.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (expected_words.size() != 0)
			report_mismatch($sformatf("%0d expected words never came", expected_words.size()));
		repeat (100) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// run limit
	initial begin
		#3_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
